@@ rtl/fgl_pkg.sv @@
`timescale 1ns / 1ps
// Package for the fuzzy gain lookup: field types, breakpoint constants
// and the 7 x 5 rule table in tenths. No dependencies.
package fgl_pkg;

    localparam int ERROR_POINTS  = 7;
    localparam int CHANGE_POINTS = 5;

    localparam int ERR_FIRST     = -12;
    localparam int ERR_STEP_LOG2 = 2;
    localparam int ERR_STEP      = 1 << ERR_STEP_LOG2;
    localparam int ERR_SPAN      = (ERROR_POINTS - 1) * ERR_STEP;
    localparam int CHG_FIRST     = -2;
    localparam int CHG_SPAN      = CHANGE_POINTS - 1;

    localparam int ROW_W   = $clog2(ERROR_POINTS);
    localparam int COL_W   = $clog2(CHANGE_POINTS);
    localparam int WEIGHT_W = ERR_STEP_LOG2 + 1;
    localparam int ENTRY_W = 5;

    typedef logic signed [7:0]   t_error;
    typedef logic signed [7:0]   t_error_change;
    typedef logic [6:0]          t_gain;
    typedef logic [ROW_W-1:0]    t_row;
    typedef logic [COL_W-1:0]    t_col;
    typedef logic [WEIGHT_W-1:0] t_weight;
    typedef logic [ENTRY_W-1:0]  t_entry;

    localparam t_entry GAIN_TABLE [ERROR_POINTS][CHANGE_POINTS] = '{
        '{5'd19, 5'd18, 5'd17, 5'd16, 5'd15},
        '{5'd14, 5'd13, 5'd12, 5'd10, 5'd9 },
        '{5'd12, 5'd10, 5'd8,  5'd7,  5'd6 },
        '{5'd5,  5'd5,  5'd4,  5'd4,  5'd4 },
        '{5'd6,  5'd7,  5'd8,  5'd10, 5'd12},
        '{5'd9,  5'd10, 5'd12, 5'd13, 5'd14},
        '{5'd15, 5'd16, 5'd17, 5'd18, 5'd19}
    };

    // Segment select on the first stage.
    typedef struct packed {
        t_row    row;
        t_col    col;
        t_weight weight;
    } t_segment;

endpackage

@@ rtl/fgl_if.sv @@
`timescale 1ns / 1ps
// Request and response channel interfaces for the fuzzy gain lookup.
// Depends on fgl_pkg.
interface fgl_req_if;
    logic                  valid;
    logic                  ready;
    fgl_pkg::t_error       error;
    fgl_pkg::t_error_change error_change;

    modport source (output valid, output error, output error_change, input ready);
    modport sink   (input valid, input error, input error_change, output ready);
endinterface

interface fgl_rsp_if;
    logic          valid;
    logic          ready;
    fgl_pkg::t_gain gain;

    modport source (output valid, output gain, input ready);
    modport sink   (input valid, input gain, output ready);
endinterface

@@ rtl/fuzzy_gain_lookup.sv @@
`timescale 1ns / 1ps
// Fuzzy gain lookup top level: two-stage pipeline from error and error
// change to an interpolated gain. Depends on fgl_pkg and fgl_if.sv.
//
// Usage:
//   i_req carries one request per handshake: a signed error and a signed
//   error change. o_rsp returns one gain per request, in units of 1/40,
//   in request order.
//   o_rsp.valid rises once the request has passed the segment register
//   r_seg and the response register r_gain. One request is taken every
//   cycle while o_rsp.ready is high; the rate is set by the two pipeline
//   registers, the segment select and the table read with the weighted sum.
//   The rule table is a constant array, read twice in the second stage.
//   When the receiver holds o_rsp.ready low the response register holds its
//   gain, the first stage fills, and i_req.ready then drops; it rises again
//   in the cycle the response is taken.
//   Reset clears both valid flags; the block is ready to accept a request
//   as soon as reset is released.
module fuzzy_gain_lookup (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fgl_req_if.sink       i_req,
    fgl_rsp_if.source     o_rsp
);
    import fgl_pkg::*;

    logic              r_v1;
    t_segment          r_seg;
    logic              r_ov;
    t_gain             r_gain;
    logic              adv_out;
    logic              adv_in;
    t_segment          n_seg;
    t_gain             n_gain;
    logic signed [8:0] err_off;
    logic signed [8:0] chg_off;
    t_entry            lo_entry;
    t_entry            hi_entry;
    logic [7:0]        lo_prod;
    logic [7:0]        hi_prod;
    logic [8:0]        sum;

    assign adv_out     = !r_ov || o_rsp.ready;
    assign adv_in      = !r_v1 || adv_out;
    assign i_req.ready = adv_in;
    assign o_rsp.valid = r_ov;
    assign o_rsp.gain  = r_gain;

    // Pick row segment, error weight and change column.
    always_comb begin
        err_off = {i_req.error[7], i_req.error} - 9'(ERR_FIRST);
        chg_off = {i_req.error_change[7], i_req.error_change} - 9'(CHG_FIRST);
        if (err_off < 0) begin
            n_seg.row    = '0;
            n_seg.weight = t_weight'(ERR_STEP);
        end else if (err_off >= 9'(ERR_SPAN)) begin
            n_seg.row    = t_row'(ERROR_POINTS - 2);
            n_seg.weight = '0;
        end else begin
            n_seg.row    = t_row'(err_off[8:ERR_STEP_LOG2]);
            n_seg.weight = t_weight'(ERR_STEP)
                         - t_weight'({1'b0, err_off[ERR_STEP_LOG2-1:0]});
        end
        if (chg_off < 0) begin
            n_seg.col = '0;
        end else if (chg_off >= 9'(CHG_SPAN)) begin
            n_seg.col = t_col'(CHG_SPAN);
        end else begin
            n_seg.col = t_col'(chg_off[COL_W-1:0]);
        end
    end

    // Blend the two rows of the chosen column.
    always_comb begin
        lo_entry = GAIN_TABLE[r_seg.row][r_seg.col];
        hi_entry = GAIN_TABLE[r_seg.row + t_row'(1)][r_seg.col];
        lo_prod  = 8'(lo_entry) * 8'(r_seg.weight);
        hi_prod  = 8'(hi_entry) * 8'(t_weight'(ERR_STEP) - r_seg.weight);
        sum      = 9'(lo_prod) + 9'(hi_prod);
        n_gain   = sum[6:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (adv_in) begin
                r_v1 <= i_req.valid;
            end
            if (adv_out) begin
                r_ov <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_in && i_req.valid) begin
            r_seg <= n_seg;
        end
        if (adv_out && r_v1) begin
            r_gain <= n_gain;
        end
    end

endmodule
